### hdl/pctd_pkg.sv
// Shared types, constants and hex helpers for the percent decoder.
`timescale 1ns / 1ps

package pctd_pkg;

  // Escape introducer
  localparam logic [7:0] PctChar = 8'h25;

  // Most decoded bytes a single input byte can release
  localparam int unsigned MaxRes = 3;

  // Result queue depth and its index width
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Parse phases
  localparam logic [1:0] PhPlain = 2'd0;
  localparam logic [1:0] PhPct   = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;

  // Results released by one request, oldest in slot 0
  typedef struct packed {
    logic [1:0]             cnt;
    logic [MaxRes-1:0][7:0] data;
    logic [MaxRes-1:0]      last;
  } res_t;

  // Uppercase hex digit: 0-9 or A-F
  function automatic logic is_upper_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of an uppercase hex digit
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

### hdl/pctd_decode.sv
// Escape parser: holds phase and pending digit, releases up to three bytes per request.
`timescale 1ns / 1ps

module pctd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output pctd_pkg::res_t   res_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  // Work out the bytes this request releases and the next parse state
  always_comb begin
    logic [1:0] n;
    logic       b_hex;
    res_o   = '0;
    n       = 2'd0;
    b_hex   = pctd_pkg::is_upper_hex(byte_i);
    phase_d = pctd_pkg::PhPlain;
    held_d  = held_q;

    if (phase_q == pctd_pkg::PhPct && b_hex) begin
      // first digit of an escape: hold it
      held_d  = byte_i;
      phase_d = pctd_pkg::PhDigit;
    end else if (phase_q == pctd_pkg::PhDigit && b_hex) begin
      // complete escape: emit the decoded byte
      res_o.data[n] = {pctd_pkg::hex_nibble(held_q), pctd_pkg::hex_nibble(byte_i)};
      n = n + 2'd1;
    end else begin
      // plain byte or failed escape: release anything held, then take the byte as plain text or start a new escape
      if (phase_q == pctd_pkg::PhPct || phase_q == pctd_pkg::PhDigit) begin
        res_o.data[n] = pctd_pkg::PctChar;
        n = n + 2'd1;
      end
      if (phase_q == pctd_pkg::PhDigit) begin
        res_o.data[n] = held_q;
        n = n + 2'd1;
      end
      if (byte_i == pctd_pkg::PctChar) begin
        phase_d = pctd_pkg::PhPct;
      end else begin
        res_o.data[n] = byte_i;
        n = n + 2'd1;
      end
    end

    // End of string: flush anything still held and mark the final byte
    if (last_i) begin
      if (phase_d == pctd_pkg::PhPct || phase_d == pctd_pkg::PhDigit) begin
        res_o.data[n] = pctd_pkg::PctChar;
        n = n + 2'd1;
      end
      if (phase_d == pctd_pkg::PhDigit) begin
        res_o.data[n] = held_d;
        n = n + 2'd1;
      end
      phase_d = pctd_pkg::PhPlain;
      res_o.last[n - 2'd1] = 1'b1;
    end

    res_o.cnt = fire_i ? n : 2'd0;
  end

  // Advance the parse state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pctd_pkg::PhPlain;
      held_q  <= 8'h00;
    end else if (fire_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### hdl/pctd_outq.sv
// Result queue: takes up to three bytes a cycle, hands out one a cycle while the receiver is ready.
`timescale 1ns / 1ps

module pctd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pctd_pkg::res_t push_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic [8:0]                    mem_q [pctd_pkg::QDepth];
  logic [pctd_pkg::QIdxW-1:0]    wr_q, rd_q;
  logic [pctd_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = mem_q[rd_q][8:1];
  assign out_last_o  = mem_q[rd_q][0];

  // Room for a full burst of results, from registered state only
  assign space_o = (cnt_q <= pctd_pkg::QCntW'(pctd_pkg::QDepth - pctd_pkg::MaxRes));

  assign cnt_d = cnt_q + pctd_pkg::QCntW'(push_i.cnt) - pctd_pkg::QCntW'(pop);

  // Store the released bytes in order behind the tail
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < pctd_pkg::MaxRes; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_q + pctd_pkg::QIdxW'(i)] <= {push_i.data[i], push_i.last[i]};
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + pctd_pkg::QIdxW'(push_i.cnt);
      rd_q  <= rd_q + pctd_pkg::QIdxW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/percent_decoder.sv
// Top level of the streaming URL percent decoder.
//
// Usage: encoded bytes enter on the in_* channel, one request per byte, with
// in_last_i set on the final byte of a string. Decoded bytes leave on the
// out_* channel, with out_last_o set on the final decoded byte. Both channels
// use valid/ready; a request moves when valid and ready are high at a clock edge.
// "%XY" with uppercase hex digits becomes one byte; anything else passes through.
// A released byte is written into the result queue when its request is accepted
// and offered once any bytes ahead of it have left. A byte may release none, one,
// two or three bytes. Throughput: one input byte per cycle while each
// byte releases at most one result and the receiver is ready; a byte that
// releases two or three holds input back while the single-byte output port
// drains the four-entry queue. Input ready depends only on queue occupancy
// (at most one result waiting). Stall: if the receiver holds out_ready_i low
// the queue fills and in_ready_o drops; nothing is lost or repeated.
// Reset: clears the parse phase, the held digit and the queue; in_ready_o is
// then high straight away, as the queue is empty.
`timescale 1ns / 1ps

module percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  pctd_pkg::res_t res;
  logic           fire;

  assign fire = in_valid_i && in_ready_o;

  // Parse the accepted byte
  pctd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_i),
    .last_i (in_last_i),
    .res_o  (res)
  );

  // Queue the released bytes towards the receiver
  pctd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
